@@ rtl/blpc_pkg.sv @@
// shared types and constants for the blocked-edge lattice path counter
// no dependencies; imported by the interfaces, the top level and the checker
package blpc_pkg;

  localparam int COORD_W = 7;
  localparam int CMD_W   = 2;
  localparam int COUNT_W = 64;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_COMPUTE = 2'd2
  } blpc_cmd_t;

  // register index as decoded from paddr[2]
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_WALK  = 5'b00100,
    S_LAST  = 5'b01000,
    S_EMIT  = 5'b10000
  } blpc_state_t;

endpackage

@@ rtl/blpc_in_if.sv @@
// input channel: command word with blocked edge coordinates
// depends on blpc_pkg
interface blpc_in_if
  import blpc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] from_x;
  logic [COORD_W-1:0] from_y;
  logic [COORD_W-1:0] to_x;
  logic [COORD_W-1:0] to_y;

  modport source (output valid, command, from_x, from_y, to_x, to_y, input ready);
  modport sink   (input valid, command, from_x, from_y, to_x, to_y, output ready);
endinterface

@@ rtl/blpc_out_if.sv @@
// result channel: saturated path count and overflow flag
// depends on blpc_pkg
interface blpc_out_if
  import blpc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] path_count;
  logic               overflow;

  modport source (output valid, path_count, overflow, input ready);
  modport sink   (input valid, path_count, overflow, output ready);
endinterface

@@ rtl/blpc_ram.sv @@
// generic single-write, single-read RAM with registered read data
// read of an address being written returns the old contents
module blpc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/blocked_edge_lattice_path_count.sv @@
// Counts monotone lattice paths from (0,0) to (grid_width, grid_height) avoiding
// blocked unit edges; grid sides above MAX_SIDE saturate to MAX_SIDE. After reset
// and after every clear command the two blocked-edge memories are swept one entry
// a cycle over all 4^ceil(log2(MAX_SIDE+1)) entries (16384 at MAX_SIDE = 127), with the
// input held off. An edge load is written to the memories as it is accepted, so loads
// stream at one word per clock while the block is idle. A compute walks the grid
// column by column, one node per cycle through the single 64-bit saturating adder and
// the column count memory port, and returns its word from the emit state once the result register is free.
// Configuration registers are on an APB-style port at byte addresses 0 and 4.
module blocked_edge_lattice_path_count
  import blpc_pkg::*;
#(
  parameter int MAX_SIDE = 127
) (
  input  logic              clk,
  input  logic              rst,
  blpc_in_if.sink           item,
  blpc_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int SIDE  = MAX_SIDE + 1;
  localparam int CW    = $clog2(SIDE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;

  blpc_state_t state;

  logic [COORD_W-1:0] grid_width;
  logic [COORD_W-1:0] grid_height;
  logic [CW-1:0]      w_lim;
  logic [CW-1:0]      h_lim;

  logic [AW-1:0]      clr_addr;
  logic [CW-1:0]      ix;
  logic [CW-1:0]      iy;

  // data stage of the walk
  logic               dv;
  logic               d_x0;
  logic               d_y0;
  logic               d_fwd;
  logic [CW-1:0]      d_y;
  logic [COUNT_W-1:0] prev;
  logic               ovf;

  logic               res_valid;
  logic [COUNT_W-1:0] res_count;
  logic               res_ovf;

  logic               accept;
  logic               load_go;
  logic               in_range;
  logic               x_fwd;
  logic               x_bwd;
  logic               y_fwd;
  logic               y_bwd;
  logic               rt_hit;
  logic               up_hit;
  logic [AW-1:0]      load_addr;

  logic               rt_we;
  logic               up_we;
  logic [AW-1:0]      blk_waddr;
  logic               blk_wdata;
  logic               rblk_rd;
  logic               ublk_rd;
  logic [COUNT_W-1:0] cnt_rd;

  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] addend;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] acc;

  logic               cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_GRID_WIDTH:  prdata = APB_DW'(grid_width);
      REG_GRID_HEIGHT: prdata = APB_DW'(grid_height);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    if (32'(grid_width) > 32'(MAX_SIDE)) begin
      w_lim = CW'(MAX_SIDE);
    end else begin
      w_lim = CW'(grid_width);
    end
    if (32'(grid_height) > 32'(MAX_SIDE)) begin
      h_lim = CW'(MAX_SIDE);
    end else begin
      h_lim = CW'(grid_height);
    end
  end

  // edge decode, straight off the input word
  assign accept  = item.valid && item.ready;
  assign load_go = accept && (item.command == CMD_ADD);

  always_comb begin
    in_range = (32'(item.from_x) <= 32'(MAX_SIDE)) && (32'(item.from_y) <= 32'(MAX_SIDE))
            && (32'(item.to_x) <= 32'(MAX_SIDE)) && (32'(item.to_y) <= 32'(MAX_SIDE));
    x_fwd  = ({1'b0, item.from_x} + 8'd1) == {1'b0, item.to_x};
    x_bwd  = ({1'b0, item.to_x} + 8'd1) == {1'b0, item.from_x};
    y_fwd  = ({1'b0, item.from_y} + 8'd1) == {1'b0, item.to_y};
    y_bwd  = ({1'b0, item.to_y} + 8'd1) == {1'b0, item.from_y};
    rt_hit = in_range && (item.from_y == item.to_y) && (x_fwd || x_bwd);
    up_hit = in_range && (item.from_x == item.to_x) && (y_fwd || y_bwd);
    // edges are stored at their lower or left end
    if (x_fwd || y_fwd) begin
      load_addr = {CW'(item.from_x), CW'(item.from_y)};
    end else begin
      load_addr = {CW'(item.to_x), CW'(item.to_y)};
    end
  end

  always_comb begin
    rt_we     = 1'b0;
    up_we     = 1'b0;
    blk_waddr = clr_addr;
    blk_wdata = 1'b0;
    if (state == S_CLEAR) begin
      rt_we = 1'b1;
      up_we = 1'b1;
    end else if (load_go) begin
      rt_we     = rt_hit;
      up_we     = up_hit;
      blk_waddr = load_addr;
      blk_wdata = 1'b1;
    end
  end

  blpc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (rt_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr ({ix - CW'(1), iy}),
    .rdata (rblk_rd)
  );

  blpc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_up_ram (
    .clk   (clk),
    .we    (up_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr ({ix, iy - CW'(1)}),
    .rdata (ublk_rd)
  );

  blpc_ram #(.WIDTH(COUNT_W), .DEPTH(SIDE)) u_count_ram (
    .clk   (clk),
    .we    (dv),
    .waddr (d_y),
    .wdata (acc),
    .raddr (iy),
    .rdata (cnt_rd)
  );

  // node update: pull from the left over the right step, add from below over the up step
  always_comb begin
    if (d_x0) begin
      base = d_y0 ? COUNT_W'(1) : '0;
    end else if (rblk_rd) begin
      base = '0;
    end else begin
      base = d_fwd ? prev : cnt_rd;
    end
    addend = (!d_y0 && !ublk_rd) ? prev : '0;
    sum    = {1'b0, base} + {1'b0, addend};
    acc    = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  end

  assign item.ready        = (state == S_IDLE);
  assign result.valid      = res_valid;
  assign result.path_count = res_count;
  assign result.overflow   = res_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      ix          <= '0;
      iy          <= '0;
      dv          <= 1'b0;
      ovf         <= 1'b0;
      res_valid   <= 1'b0;
      grid_width  <= COORD_W'(1);
      grid_height <= COORD_W'(1);
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_GRID_WIDTH:  grid_width  <= pwdata[COORD_W-1:0];
          REG_GRID_HEIGHT: grid_height <= pwdata[COORD_W-1:0];
          default:         ;
        endcase
      end

      // the emit state loads the result register itself
      if (res_valid && result.ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end

      dv <= (state == S_WALK);
      if (dv) begin
        ovf <= ovf | sum[COUNT_W];
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.command)
              CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              CMD_COMPUTE: begin
                ix    <= '0;
                iy    <= '0;
                ovf   <= 1'b0;
                state <= S_WALK;
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          if (iy == h_lim) begin
            iy <= '0;
            if (ix == w_lim) begin
              state <= S_LAST;
            end else begin
              ix <= ix + CW'(1);
            end
          end else begin
            iy <= iy + CW'(1);
          end
        end
        S_LAST: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_count <= prev;
            res_ovf   <= ovf;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // walk pipeline payload
  always_ff @(posedge clk) begin
    d_x0  <= (ix == '0);
    d_y0  <= (iy == '0);
    d_y   <= iy;
    // single-row grids read the entry being written in the same cycle
    d_fwd <= dv && (d_y == iy);
    if (dv) begin
      prev <= acc;
    end
  end

endmodule

@@ rtl/blpc_checker.sv @@
// port-level checks for the lattice path counter, bound to the top level
// depends on blpc_pkg
module blpc_checker
  import blpc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic [CMD_W-1:0]   item_command,
  input logic               result_valid,
  input logic               result_ready,
  input logic [COUNT_W-1:0] result_path_count,
  input logic               result_overflow
);

  // the clearing pass holds the input off straight after reset
  a_reset_clears: assert property (@(posedge clk) $fell(rst) |-> !item_ready)
    else $error("input ready straight after reset");

  // a compute occupies the walk sequencer
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item_command == CMD_COMPUTE) |=> !item_ready)
    else $error("input ready in the cycle after a compute word");

  // a clear starts the sweep
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item_command == CMD_CLEAR) |=> !item_ready)
    else $error("input ready in the cycle after a clear word");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_path_count)
      && $stable(result_overflow))
    else $error("stalled result word changed");

endmodule

bind blocked_edge_lattice_path_count blpc_checker u_blpc_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .item_command      (item.command),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_path_count (result.path_count),
  .result_overflow   (result.overflow)
);

@@ tb/blocked_edge_lattice_path_count_checker.sv @@
`timescale 1ns / 1ps
// checker for the blocked-edge lattice path counter: mirrors the grid registers and
// blocked-edge stores, predicts each path count word and compares the result channel
// depends on blpc_pkg, blpc_in_if and blpc_out_if
module blocked_edge_lattice_path_count_checker
  import blpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  blpc_in_if                item,
  blpc_out_if               result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fails,
  output int                counts_due
);

  localparam int SIDE = 128;

  typedef struct packed {
    logic [COUNT_W-1:0] total;
    logic               saturated;
  } path_total_t;

  logic [COORD_W-1:0] grid_w;
  logic [COORD_W-1:0] grid_h;
  bit                 right_cut [SIDE*SIDE];
  bit                 up_cut [SIDE*SIDE];
  logic [COUNT_W-1:0] column [SIDE];
  path_total_t        totals_due [$];

  function automatic void unblock_all();
    foreach (right_cut[i]) begin
      right_cut[i] = 1'b0;
      up_cut[i] = 1'b0;
    end
  endfunction

  // either end order names the same edge; anything not a unit step is dropped
  function automatic void block_edge(int fx, int fy, int tx, int ty);
    if (fy == ty) begin
      if (fx + 1 == tx) right_cut[fx * SIDE + fy] = 1'b1;
      else if (tx + 1 == fx) right_cut[tx * SIDE + ty] = 1'b1;
    end else if (fx == tx) begin
      if (fy + 1 == ty) up_cut[fx * SIDE + fy] = 1'b1;
      else if (ty + 1 == fy) up_cut[tx * SIDE + ty] = 1'b1;
    end
  endfunction

  // column by column, each node pulls from its left and lower neighbours
  function automatic path_total_t walk_grid();
    path_total_t        r;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] acc;
    r.saturated = 1'b0;
    for (int x = 0; x <= int'(grid_w); x++) begin
      for (int y = 0; y <= int'(grid_h); y++) begin
        if (x == 0) acc = (y == 0) ? COUNT_W'(1) : '0;
        else if (right_cut[(x - 1) * SIDE + y]) acc = '0;
        else acc = column[y];
        if (y > 0 && !up_cut[x * SIDE + y - 1]) begin
          sum = {1'b0, acc} + {1'b0, column[y - 1]};
          if (sum[COUNT_W]) begin
            acc = '1;
            r.saturated = 1'b1;
          end else begin
            acc = sum[COUNT_W-1:0];
          end
        end
        column[y] = acc;
      end
    end
    r.total = column[grid_h];
    return r;
  endfunction

  always @(posedge clk) begin
    path_total_t want;
    int          bad;
    bad = 0;
    if (rst) begin
      unblock_all();
      grid_w = COORD_W'(1);
      grid_h = COORD_W'(1);
      totals_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_GRID_HEIGHT) grid_h = pwdata[COORD_W-1:0];
        else grid_w = pwdata[COORD_W-1:0];
      end
      if (item.valid && item.ready) begin
        case (item.command)
          CMD_CLEAR:   unblock_all();
          CMD_ADD:     block_edge(int'(item.from_x), int'(item.from_y),
                                  int'(item.to_x), int'(item.to_y));
          CMD_COMPUTE: totals_due = {totals_due, walk_grid()};
          default:     ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (totals_due.size() == 0) begin
          $error("path count word with none expected: path_count %0d overflow %0b",
                 result.path_count, result.overflow);
          bad++;
        end else begin
          want = totals_due.pop_front();
          if (result.path_count !== want.total) begin
            $error("path_count expected %0d got %0d", want.total, result.path_count);
            bad++;
          end
          if (result.overflow !== want.saturated) begin
            $error("overflow expected %0b got %0b", want.saturated, result.overflow);
            bad++;
          end
        end
      end
    end
    fails <= fails + bad;
    counts_due <= totals_due.size();
  end

endmodule

@@ tb/blocked_edge_lattice_path_count_tb.sv @@
`timescale 1ns / 1ps
// top of the testbench for the blocked-edge lattice path counter: clock, reset,
// stimulus on the word and register ports, verdict; depends on blpc_pkg, the channel
// interfaces, the block and blocked_edge_lattice_path_count_checker
module blocked_edge_lattice_path_count_tb;
  import blpc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // slowest run: every phase clearing the whole store and walking mid-size grids
  // several times, plus the full-size walks, all with stalls; taken a few times over
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int ITEM_TARGET = 1800;
  localparam int QUIET_FROM = 1550;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              sink_ready = 1'b1;
  int                fails;
  int                counts_due;
  int unsigned       cycles_run = 0;
  int                gap_pct = 20;
  int                stall_pct = 20;
  int                stall_left = 0;
  int                acted = 0;
  logic [COORD_W-1:0] last_fx = '0;
  logic [COORD_W-1:0] last_fy = '0;
  logic [COORD_W-1:0] last_tx = '0;
  logic [COORD_W-1:0] last_ty = '0;

  blpc_in_if  item_ch ();
  blpc_out_if result_ch ();

  assign result_ch.ready = sink_ready;

  blocked_edge_lattice_path_count uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  blocked_edge_lattice_path_count_checker count_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fails      (fails),
    .counts_due (counts_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycles_run <= cycles_run + 1;

  // result side stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      sink_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] fx,
                           input logic [COORD_W-1:0] fy, input logic [COORD_W-1:0] tx,
                           input logic [COORD_W-1:0] ty);
    if ($urandom_range(0, 99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.command <= cmd;
    item_ch.from_x  <= fx;
    item_ch.from_y  <= fy;
    item_ch.to_x    <= tx;
    item_ch.to_y    <= ty;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
  endtask

  // clear, compute and the unused code carry random coordinates
  task automatic send_bare(input logic [CMD_W-1:0] cmd);
    send_word(cmd, COORD_W'($urandom_range(0, 127)), COORD_W'($urandom_range(0, 127)),
              COORD_W'($urandom_range(0, 127)), COORD_W'($urandom_range(0, 127)));
  endtask

  task automatic send_edge(input logic [COORD_W-1:0] fx, input logic [COORD_W-1:0] fy,
                           input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
    last_fx = fx;
    last_fy = fy;
    last_tx = tx;
    last_ty = ty;
    send_word(CMD_ADD, fx, fy, tx, ty);
  endtask

  // unit edge inside a w by h grid, ends in either order; a point grid uses the whole store
  task automatic send_unit_edge(input int w, input int h);
    int x;
    int y;
    bit horiz;
    if (w == 0 && h == 0) begin
      w = 127;
      h = 127;
    end
    horiz = (h == 0) ? 1'b1 : (w == 0) ? 1'b0 : 1'($urandom_range(0, 1));
    x = horiz ? $urandom_range(0, w - 1) : $urandom_range(0, w);
    y = horiz ? $urandom_range(0, h) : $urandom_range(0, h - 1);
    if ($urandom_range(0, 1)) begin
      send_edge(COORD_W'(x), COORD_W'(y),
                COORD_W'(x + int'(horiz)), COORD_W'(y + int'(!horiz)));
    end else begin
      send_edge(COORD_W'(x + int'(horiz)), COORD_W'(y + int'(!horiz)),
                COORD_W'(x), COORD_W'(y));
    end
  endtask

  // words the block drops: not a unit edge, or the unused command code
  task automatic send_noise();
    int a;
    int b;
    a = $urandom_range(0, 125);
    b = $urandom_range(0, 125);
    case ($urandom_range(0, 4))
      0:       send_word(CMD_ADD, COORD_W'(a), COORD_W'(b), COORD_W'(a), COORD_W'(b));
      1:       send_word(CMD_ADD, COORD_W'(a + 1), COORD_W'(b), COORD_W'(a),
                         COORD_W'(b + 1));
      2:       send_word(CMD_ADD, COORD_W'(a), COORD_W'(b),
                         COORD_W'(a + 2 + int'($urandom_range(0, 125 - a))), COORD_W'(b));
      3:       send_word(CMD_ADD, COORD_W'(b),
                         COORD_W'(a + 2 + int'($urandom_range(0, 125 - a))),
                         COORD_W'(b), COORD_W'(a));
      default: send_bare(CMD_UNUSED);
    endcase
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input int v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (counts_due != 0) @(posedge clk);
  endtask

  // only called after a compute word, so the block is idle once its count is back
  task automatic set_grid(input int w, input int h);
    drain();
    repeat (4) @(posedge clk);
    apb_write({REG_GRID_WIDTH, 2'b00}, w);
    apb_write({REG_GRID_HEIGHT, 2'b00}, h);
  endtask

  task automatic run_phase();
    int w;
    int h;
    int r;
    case ($urandom_range(0, 9))
      0:       begin w = $urandom_range(0, 3);     h = $urandom_range(0, 3);     end
      1, 2:    begin w = $urandom_range(30, 45);   h = $urandom_range(30, 45);   end
      3:       begin w = $urandom_range(100, 127); h = $urandom_range(0, 3);     end
      4:       begin w = $urandom_range(0, 3);     h = $urandom_range(100, 127); end
      default: begin w = $urandom_range(1, 12);    h = $urandom_range(1, 12);    end
    endcase
    if (acted >= QUIET_FROM) begin
      gap_pct = 0;
      stall_pct = 0;
    end else begin
      case ($urandom_range(0, 2))
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 10; stall_pct = 10; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
    end
    set_grid(w, h);
    if ($urandom_range(0, 1)) begin
      send_bare(CMD_CLEAR);
      acted++;
    end
    repeat ($urandom_range(20, 50)) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_bare(CMD_COMPUTE);
        acted++;
      end else if (r < 50) begin
        send_unit_edge(w, h);
        acted++;
      end else if (r < 72) begin
        send_unit_edge(127, 127);
        acted++;
      end else if (r < 82) begin
        send_word(CMD_ADD, last_tx, last_ty, last_fx, last_fy);
        acted++;
      end else begin
        send_noise();
        acted++;
      end
    end
    send_bare(CMD_COMPUTE);
    acted++;
  endtask

  initial begin
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    item_ch.valid   <= 1'b0;
    item_ch.command <= CMD_CLEAR;
    item_ch.from_x  <= '0;
    item_ch.from_y  <= '0;
    item_ch.to_x    <= '0;
    item_ch.to_y    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset grid is 1 by 1
    send_bare(CMD_COMPUTE);
    send_edge(0, 0, 1, 0);
    send_bare(CMD_COMPUTE);
    send_edge(1, 0, 0, 0);
    send_word(CMD_ADD, 1, 1, 1, 1);
    send_word(CMD_ADD, 0, 0, 1, 1);
    send_word(CMD_ADD, 0, 1, 2, 1);
    send_edge(5, 5, 5, 6);
    send_word(CMD_UNUSED, 127, 127, 127, 127);
    send_bare(CMD_COMPUTE);
    send_edge(0, 1, 0, 0);
    send_edge(127, 127, 126, 127);
    send_edge(127, 126, 127, 127);
    send_bare(CMD_COMPUTE);
    send_bare(CMD_CLEAR);
    send_bare(CMD_COMPUTE);
    // full size saturates, then cut off the far corner: zero count, flag still set
    set_grid(127, 127);
    send_bare(CMD_COMPUTE);
    send_edge(127, 127, 126, 127);
    send_edge(127, 126, 127, 127);
    send_bare(CMD_COMPUTE);
    set_grid(0, 0);
    send_bare(CMD_COMPUTE);
    set_grid(0, 127);
    send_bare(CMD_COMPUTE);
    set_grid(127, 0);
    send_bare(CMD_COMPUTE);
    send_bare(CMD_CLEAR);
    send_bare(CMD_COMPUTE);
    acted = 20;

    while (acted < ITEM_TARGET) run_phase();

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0 && counts_due == 0) begin
      $display("blocked_edge_lattice_path_count_tb: clean");
    end else begin
      $display("blocked_edge_lattice_path_count_tb: errors");
    end
    $finish;
  end

  initial begin
    wait (cycles_run == CYCLE_LIMIT);
    $display("blocked_edge_lattice_path_count_tb: errors");
    $finish;
  end

endmodule
